>>> sv/apss_pkg.sv
package apss_pkg;

  localparam int MAX_DIVISOR = 32;
  localparam int CLOCK_RATIO = 384;

  localparam int CFG_W   = 32;
  localparam int REQ_W   = 24;
  localparam int PRESC_W = 6;
  localparam int WORD_W  = 16;

  localparam logic [WORD_W-1:0] PRESCALE_ENABLE = WORD_W'(1) << 15;

  // widest base rate: full-scale master clock over the clock ratio
  localparam int BASE_W = $clog2(((64'd1 << CFG_W) - 64'd1) / CLOCK_RATIO + 64'd1);
  localparam int CMP_W  = (REQ_W > BASE_W) ? REQ_W : BASE_W;
  // divisor index and choice reach MAX_DIVISOR + 1
  localparam int CH_W   = $clog2(MAX_DIVISOR + 2);
  localparam int DEN_W  = ($clog2(CLOCK_RATIO + 1) > CH_W) ? $clog2(CLOCK_RATIO + 1) : CH_W;
  localparam int CNT_W  = $clog2(CFG_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SCAN,
    ST_UP,
    ST_DOWN,
    ST_PICK,
    ST_DONE
  } apss_state_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] num;
    logic [DEN_W-1:0] den;
  } apss_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] quo;
  } apss_div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic               accepted;
    logic [PRESC_W-1:0] presc;
    logic [WORD_W-1:0]  word;
  } apss_res_t;

endpackage

>>> sv/apss_div.sv
module apss_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  apss_pkg::apss_div_req_t req_i,
  output apss_pkg::apss_div_rsp_t rsp_o
);
  import apss_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [CFG_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // one restoring step per cycle, MSB first
  always_comb begin
    rem_sh   = {rem_r, quo_r[CFG_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    rem_nxt  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (req_i.start) begin
        cnt_r <= CNT_W'(CFG_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r <= '0;
      quo_r <= req_i.num;
      den_r <= req_i.den;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[CFG_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_i.start |-> (cnt_r == '0) && !done_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (den_r != '0) |-> rem_r < den_r)
    else $error("partial remainder not below divisor");

endmodule

>>> sv/apss_ctrl.sv
module apss_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [apss_pkg::REQ_W-1:0]      in_req,
  input  logic [apss_pkg::CFG_W-1:0]      cfg_clk,
  input  logic                            slot_free,
  output logic                            busy,
  output apss_pkg::apss_div_req_t         div_req,
  input  apss_pkg::apss_div_rsp_t         div_rsp,
  output apss_pkg::apss_res_t             res
);
  import apss_pkg::*;

  apss_state_t       state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [CH_W-1:0]   i_r, i_nxt;
  logic [BASE_W-1:0] r_mid_r, r_mid_nxt;
  logic [BASE_W-1:0] r_up_r, r_up_nxt;
  logic [BASE_W-1:0] r_down_r, r_down_nxt;
  logic              start_r, start_nxt;
  logic              acc_r, acc_nxt;
  logic [CH_W-1:0]   presc_r, presc_nxt;

  logic [BASE_W-1:0] q;
  logic              reject;
  logic              below;
  logic [CMP_W-1:0]  e_mid, e_up, e_down;
  logic [CH_W-1:0]   choice;

  function automatic logic [CMP_W-1:0] abs_err(logic [BASE_W-1:0] r, logic [REQ_W-1:0] t);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(r);
    b = CMP_W'(t);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    q      = div_rsp.quo[BASE_W-1:0];
    reject = CMP_W'(req_r) > CMP_W'(q >> 1);
    below  = CMP_W'(q) < CMP_W'(req_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_BASE;
      ST_BASE: if (div_rsp.done) state_nxt = reject ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (div_rsp.done && (below || i_r == CH_W'(MAX_DIVISOR - 1))) begin
          state_nxt = ST_UP;
        end
      end
      ST_UP:   if (div_rsp.done) state_nxt = ST_DOWN;
      ST_DOWN: if (div_rsp.done) state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_DONE;
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt    = req_r;
    base_nxt   = base_r;
    i_nxt      = i_r;
    r_mid_nxt  = r_mid_r;
    r_up_nxt   = r_up_r;
    r_down_nxt = r_down_r;
    acc_nxt    = acc_r;
    presc_nxt  = presc_r;

    e_mid  = abs_err(r_mid_r, req_r);
    e_up   = abs_err(r_up_r, req_r);
    e_down = abs_err(r_down_r, req_r);
    choice = i_r;
    if (e_up < e_mid) choice = i_r + CH_W'(1);
    if (e_down < e_mid) choice = i_r - CH_W'(1);

    case (state_r)
      ST_IDLE: req_nxt = in_req;
      ST_BASE: begin
        if (div_rsp.done) begin
          base_nxt  = q;
          i_nxt     = CH_W'(1);
          acc_nxt   = !reject;
          presc_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (div_rsp.done) begin
          r_mid_nxt = q;
          if (!below) i_nxt = i_r + CH_W'(1);
        end
      end
      ST_UP:   if (div_rsp.done) r_up_nxt = q;
      ST_DOWN: begin
        if (div_rsp.done) r_down_nxt = (i_r == CH_W'(1)) ? '0 : q;
      end
      ST_PICK: presc_nxt = (choice == '0) ? '0 : choice - CH_W'(1);
      ST_DONE: ;
      default: ;
    endcase

    start_nxt = (state_nxt == ST_BASE || state_nxt == ST_SCAN ||
                 state_nxt == ST_UP || state_nxt == ST_DOWN) &&
                ((state_nxt != state_r) || div_rsp.done);

    busy = (state_r != ST_IDLE);

    div_req.start = start_r;
    div_req.num   = (state_r == ST_BASE) ? cfg_clk : CFG_W'(base_r);
    case (state_r)
      ST_BASE: div_req.den = DEN_W'(CLOCK_RATIO);
      ST_UP:   div_req.den = DEN_W'(i_r) + DEN_W'(1);
      ST_DOWN: div_req.den = DEN_W'(i_r) - DEN_W'(1);
      default: div_req.den = DEN_W'(i_r);
    endcase

    res.valid    = (state_r == ST_DONE);
    res.accepted = acc_r;
    res.presc    = PRESC_W'(presc_r);
    res.word     = acc_r ? (WORD_W'(presc_r) | PRESCALE_ENABLE) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    base_r   <= base_nxt;
    i_r      <= i_nxt;
    r_mid_r  <= r_mid_nxt;
    r_up_r   <= r_up_nxt;
    r_down_r <= r_down_nxt;
    acc_r    <= acc_nxt;
    presc_r  <= presc_nxt;
  end

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (i_r >= CH_W'(1)) && (i_r < CH_W'(MAX_DIVISOR)))
    else $error("divisor index out of range during scan");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && acc_r |-> presc_r <= CH_W'(MAX_DIVISOR))
    else $error("prescale beyond largest divisor");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && slot_free |=> state_r == ST_IDLE && !start_r)
    else $error("sequencer did not return to idle after handoff");

endmodule

>>> sv/audio_prescaler_select_unit.sv
// Audio prescaler select unit.
// Input channel (in_valid / in_stall / in_requested_rate): one requested
// sample rate per transfer. in_stall is high while a request is in work.
// Result channel (out_valid / out_stall / out_*): one result per request:
// accepted flag, prescale value and prescale register word (enable bit 15).
// Config channel (cfg_valid / cfg_ready / cfg_data): master clock in hertz;
// cfg_ready is always high, write only while no request is outstanding.
// Sequence: a single 32-step restoring divider does every division. Base
// rate: 1 division; a rejected request goes to the output after it.
// Accepted: base, up to MAX_DIVISOR-1 scan divisions, then two neighbour
// divisions. One request in work at a time; the next can be taken in the
// cycle after the result is registered.
// A finished result sits in the output register, so the next request is
// taken while it waits. A stalled result holds until out_stall drops.
// Reset: master clock register clears to zero, no result pending.
module audio_prescaler_select_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [apss_pkg::REQ_W-1:0]      in_requested_rate,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [apss_pkg::PRESC_W-1:0]    out_prescale_value,
  output logic [apss_pkg::WORD_W-1:0]     out_prescale_register_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apss_pkg::CFG_W-1:0]      cfg_data
);
  import apss_pkg::*;

  logic [CFG_W-1:0]   cfg_r;
  logic               out_valid_r, out_valid_nxt;
  logic               acc_r;
  logic [PRESC_W-1:0] presc_r;
  logic [WORD_W-1:0]  word_r;

  logic               slot_free;
  logic               load;
  logic               busy;
  apss_div_req_t      div_req;
  apss_div_rsp_t      div_rsp;
  apss_res_t          res;

  apss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  apss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_requested_rate),
    .cfg_clk   (cfg_r),
    .slot_free (slot_free),
    .busy      (busy),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res       (res)
  );

  always_comb begin
    slot_free     = !out_valid_r || !out_stall;
    load          = res.valid && slot_free;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r   <= res.accepted;
      presc_r <= res.presc;
      word_r  <= res.word;
    end
  end

  assign in_stall                   = busy;
  assign cfg_ready                  = 1'b1;
  assign out_valid                  = out_valid_r;
  assign out_accepted               = acc_r;
  assign out_prescale_value         = presc_r;
  assign out_prescale_register_word = word_r;

endmodule

>>> test/audio_prescaler_select_unit_tb.sv
module audio_prescaler_select_unit_tb;
  import apss_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic [PRESC_W-1:0] presc;
    logic [WORD_W-1:0]  word;
  } prescale_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] mclk;
    logic [REQ_W-1:0] rate;
    logic             known;
    prescale_result_t want;
  } rate_row_t;

  localparam prescale_result_t REJECTED = '0;
  localparam prescale_result_t UNTYPED  = '0;
  localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int ROWS = 22;

  // typed rows: reset clock, extremes and rejections; the rest go through the predictor
  localparam rate_row_t RATE_ROWS [ROWS] = '{
    '{32'd0,          24'd0,       1'b1, '{1'b1, 6'd31, 16'h801F}},
    '{32'd0,          24'd1,       1'b1, REJECTED},
    '{32'd0,          24'hFFFFFF,  1'b1, REJECTED},
    '{32'd383,        24'd0,       1'b1, '{1'b1, 6'd31, 16'h801F}},
    '{32'd383,        24'd1,       1'b1, REJECTED},
    '{32'd768,        24'd1,       1'b0, UNTYPED},
    '{32'd768,        24'd2,       1'b1, REJECTED},
    '{32'hFFFFFFFF,   24'd0,       1'b1, '{1'b1, 6'd32, 16'h8020}},
    '{32'hFFFFFFFF,   24'd1,       1'b0, UNTYPED},
    '{32'hFFFFFFFF,   24'd360800,  1'b0, UNTYPED},
    '{32'hFFFFFFFF,   24'd5592405, 1'b0, UNTYPED},
    '{32'hFFFFFFFF,   24'd5592406, 1'b1, REJECTED},
    '{32'hFFFFFFFF,   24'hFFFFFF,  1'b1, REJECTED},
    '{32'd12288000,   24'd16000,   1'b0, UNTYPED},
    '{32'd12288000,   24'd16001,   1'b1, REJECTED},
    '{32'd12288000,   24'd13333,   1'b0, UNTYPED},
    '{32'd12288000,   24'd1000,    1'b0, UNTYPED},
    '{32'd12288000,   24'd8000,    1'b0, UNTYPED},
    '{32'd16934400,   24'd1379,    1'b0, UNTYPED},
    '{32'd16934400,   24'd22050,   1'b0, UNTYPED},
    '{32'd16934400,   24'd44100,   1'b1, REJECTED},
    '{32'd0,          24'd0,       1'b1, '{1'b1, 6'd31, 16'h801F}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_requested_rate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_accepted;
  logic [PRESC_W-1:0]  out_prescale_value;
  logic [WORD_W-1:0]   out_prescale_register_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  prescale_result_t    pending_results [$];
  logic [CFG_W-1:0]    master_clock_hz = '0;
  int unsigned         mismatches = 0;
  int unsigned         results_seen = 0;
  longint unsigned     cycle_count = 0;
  bit                  feed_done = 1'b0;
  bit                  squeezed = 1'b0;

  audio_prescaler_select_unit u_top (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_requested_rate          (in_requested_rate),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_accepted               (out_accepted),
    .out_prescale_value         (out_prescale_value),
    .out_prescale_register_word (out_prescale_register_word),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_data                   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [31:0] rate_error(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic prescale_result_t predict_prescale(input logic [REQ_W-1:0] rate,
                                                        input logic [CFG_W-1:0] mclk);
    logic [31:0] base;
    logic [31:0] req;
    logic [31:0] r_mid;
    logic [31:0] r_up;
    logic [31:0] r_down;
    logic [31:0] e_mid;
    int unsigned div;
    int unsigned choice;
    prescale_result_t res;
    res = '0;
    req = 32'(rate);
    base = mclk / CLOCK_RATIO;
    if (req > (base >> 1)) begin
      return res;
    end
    r_mid = '0;
    for (div = 1; div < MAX_DIVISOR; div++) begin
      r_mid = base / div;
      if (r_mid < req) break;
    end
    r_up = base / (div + 1);
    r_down = (div > 1) ? base / (div - 1) : 32'd0;
    e_mid = rate_error(r_mid, req);
    choice = div;
    if (rate_error(r_up, req) < e_mid) choice = div + 1;
    // the lower neighbour wins over the upper one
    if (rate_error(r_down, req) < e_mid) choice = div - 1;
    choice = (choice > 0) ? choice - 1 : 0;
    res.accepted = 1'b1;
    res.presc = PRESC_W'(choice);
    res.word = WORD_W'(choice) | PRESCALE_ENABLE;
    return res;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 88) return $urandom_range(1, 4);
    if (sel < 98) return $urandom_range(5, 60);
    return $urandom_range(200, 1500);
  endfunction

  function automatic logic [REQ_W-1:0] pick_rate(input logic [CFG_W-1:0] mclk);
    int base;
    int v;
    int unsigned sel;
    base = int'(mclk / CLOCK_RATIO);
    sel = $urandom_range(0, 99);
    if (sel >= 90) return REQ_W'($urandom);
    if (sel < 55) begin
      v = base / int'($urandom_range(2, 36)) + int'($urandom_range(0, 6)) - 3;
    end else if (sel < 80) begin
      v = int'($urandom_range(0, base >> 1));
    end else begin
      v = (base >> 1) + int'($urandom_range(0, 2)) - 1;
    end
    if (v < 0) v = 0;
    return REQ_W'(v);
  endfunction

  task automatic write_master_clock(input logic [CFG_W-1:0] hz);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= hz;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    master_clock_hz = hz;
  endtask

  task automatic offer_rate(input logic [REQ_W-1:0] rate, input logic known,
                            input prescale_result_t typed, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_requested_rate <= rate;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(known ? typed : predict_prescale(rate, master_clock_hz));
  endtask

  initial begin : feeder
    logic [CFG_W-1:0] next_clk;
    wait (rst_n === 1'b1);
    @(posedge clk);
    foreach (RATE_ROWS[n]) begin
      if (RATE_ROWS[n].mclk != master_clock_hz) write_master_clock(RATE_ROWS[n].mclk);
      offer_rate(RATE_ROWS[n].rate, RATE_ROWS[n].known, RATE_ROWS[n].want, idle_gap());
    end
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: next_clk = 32'd12288000;
        1: next_clk = 32'd16934400;
        2: next_clk = 32'hFFFFFFFF;
        3: next_clk = $urandom_range(0, 30000);
        4: next_clk = $urandom;
        default: next_clk = $urandom_range(1000000, 50000000);
      endcase
      write_master_clock(next_clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_rate(pick_rate(master_clock_hz), 1'b0, UNTYPED, (n < 25) ? 0 : idle_gap());
      end
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin : drain
    int unsigned sel;
    int unsigned span;
    int unsigned held;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!squeezed && results_seen >= 40) begin
        // long hold-off: result register fills and the input stalls
        out_stall <= 1'b1;
        held = 0;
        while (held < 4000) begin
          @(posedge clk);
          held++;
        end
        squeezed = 1'b1;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 300);
        end else begin
          out_stall <= 1'b1;
          span = (sel < 90) ? $urandom_range(1, 4) :
                 (sel < 98) ? $urandom_range(5, 60) : $urandom_range(100, 600);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    prescale_result_t got;
    prescale_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.accepted = out_accepted;
      got.presc = out_prescale_value;
      got.word = out_prescale_register_word;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("transfer %0d: result with none expected, acc=%0b presc=%0d word=%h",
                   results_seen, got.accepted, got.presc, got.word);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("transfer %0d: expected acc=%0b presc=%0d word=%h, got acc=%0b presc=%0d word=%h",
                     results_seen, want.accepted, want.presc, want.word,
                     got.accepted, got.presc, got.word);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
